[rtl/ldpw_pkg.sv]
// ----------------------------------------------------------------------------
// ldpw_pkg
// Shared types, constants and helpers for the line draw pixel writer.
// ----------------------------------------------------------------------------
package ldpw_pkg;

    localparam int COORD_BITS   = 16;
    localparam int ADDRESS_BITS = 32;

    localparam int SPAN_BITS = COORD_BITS + 1;
    localparam int ERR_BITS  = COORD_BITS + 3;
    localparam int E2_BITS   = COORD_BITS + 4;
    localparam int COLB_BITS = COORD_BITS + 3;
    localparam int PROD_BITS = COORD_BITS + 16;
    localparam int CHK_BITS  = ((COORD_BITS + 16 > 32) ? COORD_BITS + 16 : 32) + 2;

    localparam logic OP_START = 1'b0;
    localparam logic OP_STEP  = 1'b1;

    localparam logic [1:0] FMT_8  = 2'd0;
    localparam logic [1:0] FMT_16 = 2'd1;
    localparam logic [1:0] FMT_32 = 2'd2;

    typedef logic [COORD_BITS-1:0]   coord_t;
    typedef logic [ADDRESS_BITS-1:0] addr_t;

    typedef enum logic [1:0] {
        KIND_ACCEPT = 2'd0,
        KIND_REJECT = 2'd1,
        KIND_WRITE  = 2'd2,
        KIND_IDLE   = 2'd3
    } kind_t;

    typedef struct packed {
        logic        opcode;
        coord_t      start_x;
        coord_t      start_y;
        coord_t      end_x;
        coord_t      end_y;
        logic [31:0] line_color;
        logic [1:0]  pixel_format;
        addr_t       base_address;
        logic [15:0] row_pitch;
    } cmd_t;

    typedef struct packed {
        kind_t       kind;
        logic [31:0] write_address;
        logic [2:0]  write_bytes;
        logic [31:0] write_data;
        logic        last_pixel;
    } res_t;

    function automatic logic [2:0] bytes_of_format(input logic [1:0] fmt);
        logic [2:0] b;
        unique case (fmt)
            FMT_8:   b = 3'd1;
            FMT_16:  b = 3'd2;
            FMT_32:  b = 3'd4;
            default: b = 3'd0;
        endcase
        return b;
    endfunction

    function automatic logic [1:0] shift_of_format(input logic [1:0] fmt);
        logic [1:0] s;
        unique case (fmt)
            FMT_16:  s = 2'd1;
            FMT_32:  s = 2'd2;
            default: s = 2'd0;
        endcase
        return s;
    endfunction

    function automatic logic [31:0] mask_color(input logic [31:0] color,
                                               input logic [2:0]  nbytes);
        logic [31:0] d;
        unique case (nbytes)
            3'd1:    d = {24'd0, color[7:0]};
            3'd2:    d = {16'd0, color[15:0]};
            default: d = color;
        endcase
        return d;
    endfunction

endpackage

[rtl/line_draw_pixel_writer_top.sv]
// ----------------------------------------------------------------------------
// line_draw_pixel_writer_top
// Bresenham line engine producing one framebuffer pixel write per step.
//
//   channel   signals                              direction
//   cmd       cmd_valid/cmd_ready + request fields  in
//   res       res_valid/res_ready + result fields   out
//   cfg       cfg_we/cfg_wdata (memory_size)        in
//
// one request per cycle sustained while res_ready is high; a request passes the
// input register, then check/step logic into the result register
// reset clears the line state and memory_size; no clearing pass
// a stalled result holds the result register; the input register still
// takes one request, then cmd_ready drops until res_ready returns
// ----------------------------------------------------------------------------
module line_draw_pixel_writer_top (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [31:0] cfg_wdata,
    input  logic        cmd_valid,
    output logic        cmd_ready,
    input  logic        opcode,
    input  logic [15:0] start_x,
    input  logic [15:0] start_y,
    input  logic [15:0] end_x,
    input  logic [15:0] end_y,
    input  logic [31:0] line_color,
    input  logic [1:0]  pixel_format,
    input  logic [31:0] base_address,
    input  logic [15:0] row_pitch,
    output logic        res_valid,
    input  logic        res_ready,
    output logic [1:0]  kind,
    output logic [31:0] write_address,
    output logic [2:0]  write_bytes,
    output logic [31:0] write_data,
    output logic        last_pixel
);

    logic [31:0]     memory_size_reg;
    logic            hold_valid_reg, hold_valid_next;
    ldpw_pkg::cmd_t  hold_cmd_reg;
    logic            res_valid_reg, res_valid_next;
    ldpw_pkg::res_t  res_reg;
    ldpw_pkg::cmd_t  cmd_in;
    ldpw_pkg::res_t  res_calc;
    logic            cmd_accept;
    logic            advance;

    assign cmd_in = '{
        opcode:       opcode,
        start_x:      start_x[ldpw_pkg::COORD_BITS-1:0],
        start_y:      start_y[ldpw_pkg::COORD_BITS-1:0],
        end_x:        end_x[ldpw_pkg::COORD_BITS-1:0],
        end_y:        end_y[ldpw_pkg::COORD_BITS-1:0],
        line_color:   line_color,
        pixel_format: pixel_format,
        base_address: base_address[ldpw_pkg::ADDRESS_BITS-1:0],
        row_pitch:    row_pitch
    };

    assign advance    = hold_valid_reg && (!res_valid_reg || res_ready);
    assign cmd_ready  = !hold_valid_reg || advance;
    assign cmd_accept = cmd_valid && cmd_ready;

    always_comb
    begin
        hold_valid_next = hold_valid_reg;
        if (cmd_accept)
        begin
            hold_valid_next = 1'b1;
        end
        else if (advance)
        begin
            hold_valid_next = 1'b0;
        end
    end

    always_comb
    begin
        res_valid_next = res_valid_reg;
        if (advance)
        begin
            res_valid_next = 1'b1;
        end
        else if (res_ready)
        begin
            res_valid_next = 1'b0;
        end
    end

    ldpw_engine u_engine (
        .clk         (clk),
        .rst_n       (rst_n),
        .advance     (advance),
        .cmd         (hold_cmd_reg),
        .memory_size (memory_size_reg),
        .res         (res_calc)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            memory_size_reg <= '0;
            hold_valid_reg  <= 1'b0;
            res_valid_reg   <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                memory_size_reg <= cfg_wdata;
            end
            hold_valid_reg <= hold_valid_next;
            res_valid_reg  <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd_accept)
        begin
            hold_cmd_reg <= cmd_in;
        end
        if (advance)
        begin
            res_reg <= res_calc;
        end
    end

    assign res_valid     = res_valid_reg;
    assign kind          = res_reg.kind;
    assign write_address = res_reg.write_address;
    assign write_bytes   = res_reg.write_bytes;
    assign write_data    = res_reg.write_data;
    assign last_pixel    = res_reg.last_pixel;

    assert property (@(posedge clk) disable iff (!rst_n)
        (!res_valid || res_ready) |-> cmd_ready)
        else $error("request blocked while result side is free");

    assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> ((kind == ldpw_pkg::KIND_WRITE) == (write_bytes != 3'd0)))
        else $error("write size disagrees with result kind");

    assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && last_pixel |-> (kind == ldpw_pkg::KIND_WRITE))
        else $error("last pixel flag without a write");

    assert property (@(posedge clk) disable iff (!rst_n)
        hold_valid_reg && !advance |=> hold_valid_reg && $stable(hold_cmd_reg))
        else $error("held request lost before processing");

endmodule

[rtl/ldpw_end_check.sv]
// ----------------------------------------------------------------------------
// ldpw_end_check
// Bounds check of one line endpoint against the row pitch and memory size.
// ----------------------------------------------------------------------------
module ldpw_end_check (
    input  ldpw_pkg::coord_t                 col,
    input  ldpw_pkg::coord_t                 row,
    input  logic [1:0]                       shift,
    input  logic [15:0]                      pitch,
    input  ldpw_pkg::addr_t                  base,
    input  logic [31:0]                      memory_size,
    output logic [ldpw_pkg::PROD_BITS-1:0]   row_off,
    output logic                             fits
);

    logic [ldpw_pkg::COLB_BITS-1:0] col_end;
    logic [ldpw_pkg::CHK_BITS-1:0]  total;
    logic                           pitch_ok;

    // (col + 1) * bytes per pixel
    assign col_end  = ldpw_pkg::COLB_BITS'({1'b0, col} + {{ldpw_pkg::COORD_BITS{1'b0}}, 1'b1})
                      << shift;
    assign row_off  = ldpw_pkg::PROD_BITS'(row) * ldpw_pkg::PROD_BITS'(pitch);
    assign pitch_ok = 32'(col_end) <= 32'(pitch);
    assign total    = ldpw_pkg::CHK_BITS'(base) + ldpw_pkg::CHK_BITS'(row_off)
                      + ldpw_pkg::CHK_BITS'(col_end);
    assign fits     = pitch_ok && (total <= ldpw_pkg::CHK_BITS'(memory_size));

endmodule

[rtl/ldpw_engine.sv]
// ----------------------------------------------------------------------------
// ldpw_engine
// Line state, command check and one Bresenham step per request.
// ----------------------------------------------------------------------------
module ldpw_engine (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 advance,
    input  ldpw_pkg::cmd_t       cmd,
    input  logic [31:0]          memory_size,
    output ldpw_pkg::res_t       res
);

    logic                                busy_reg, busy_next;
    ldpw_pkg::coord_t                    cur_col_reg, cur_col_next;
    ldpw_pkg::coord_t                    cur_row_reg, cur_row_next;
    ldpw_pkg::coord_t                    target_col_reg, target_col_next;
    ldpw_pkg::coord_t                    target_row_reg, target_row_next;
    logic                                col_neg_reg, col_neg_next;
    logic                                row_neg_reg, row_neg_next;
    logic signed [ldpw_pkg::ERR_BITS-1:0]  error_reg, error_next;
    logic signed [ldpw_pkg::SPAN_BITS-1:0] span_x_reg, span_x_next;
    logic signed [ldpw_pkg::SPAN_BITS-1:0] span_y_neg_reg, span_y_neg_next;
    logic [31:0]                         color_reg, color_next;
    logic [2:0]                          bytes_reg, bytes_next;
    logic [1:0]                          shift_reg, shift_next;
    ldpw_pkg::addr_t                     row_addr_reg, row_addr_next;
    logic [15:0]                         pitch_reg, pitch_next;

    logic [ldpw_pkg::PROD_BITS-1:0] row_off0;
    logic [ldpw_pkg::PROD_BITS-1:0] row_off1;
    logic                           fits0;
    logic                           fits1;
    logic [2:0]                     cmd_bytes;
    logic [1:0]                     cmd_shift;
    logic                           reject;
    ldpw_pkg::coord_t               dx;
    ldpw_pkg::coord_t               dy;
    logic                           at_end;
    logic signed [ldpw_pkg::E2_BITS-1:0]  e2;
    logic                           step_col;
    logic                           step_row;
    logic signed [ldpw_pkg::E2_BITS-1:0]  err_sum;
    logic [ldpw_pkg::COORD_BITS+1:0] col_off;
    ldpw_pkg::addr_t                pix_addr;

    assign cmd_bytes = ldpw_pkg::bytes_of_format(cmd.pixel_format);
    assign cmd_shift = ldpw_pkg::shift_of_format(cmd.pixel_format);

    ldpw_end_check u_check0 (
        .col         (cmd.start_x),
        .row         (cmd.start_y),
        .shift       (cmd_shift),
        .pitch       (cmd.row_pitch),
        .base        (cmd.base_address),
        .memory_size (memory_size),
        .row_off     (row_off0),
        .fits        (fits0)
    );

    ldpw_end_check u_check1 (
        .col         (cmd.end_x),
        .row         (cmd.end_y),
        .shift       (cmd_shift),
        .pitch       (cmd.row_pitch),
        .base        (cmd.base_address),
        .memory_size (memory_size),
        .row_off     (row_off1),
        .fits        (fits1)
    );

    assign reject = (cmd_bytes == 3'd0) || (cmd.row_pitch == 16'd0) || !fits0 || !fits1
                    || (row_off1 != row_off1);

    assign dx = (cmd.end_x > cmd.start_x) ? cmd.end_x - cmd.start_x : cmd.start_x - cmd.end_x;
    assign dy = (cmd.end_y > cmd.start_y) ? cmd.end_y - cmd.start_y : cmd.start_y - cmd.end_y;

    assign at_end   = (cur_col_reg == target_col_reg) && (cur_row_reg == target_row_reg);
    assign e2       = ldpw_pkg::E2_BITS'(error_reg) <<< 1;
    assign step_col = e2 >= ldpw_pkg::E2_BITS'(span_y_neg_reg);
    assign step_row = e2 <= ldpw_pkg::E2_BITS'(span_x_reg);
    assign err_sum  = ldpw_pkg::E2_BITS'(error_reg)
                      + (step_col ? ldpw_pkg::E2_BITS'(span_y_neg_reg) : '0)
                      + (step_row ? ldpw_pkg::E2_BITS'(span_x_reg) : '0);

    assign col_off  = {2'b00, cur_col_reg} << shift_reg;
    assign pix_addr = row_addr_reg + ldpw_pkg::ADDRESS_BITS'(col_off);

    always_comb
    begin
        busy_next       = busy_reg;
        cur_col_next    = cur_col_reg;
        cur_row_next    = cur_row_reg;
        target_col_next = target_col_reg;
        target_row_next = target_row_reg;
        col_neg_next    = col_neg_reg;
        row_neg_next    = row_neg_reg;
        error_next      = error_reg;
        span_x_next     = span_x_reg;
        span_y_neg_next = span_y_neg_reg;
        color_next      = color_reg;
        bytes_next      = bytes_reg;
        shift_next      = shift_reg;
        row_addr_next   = row_addr_reg;
        pitch_next      = pitch_reg;
        res             = '{kind: ldpw_pkg::KIND_IDLE, default: '0};

        if (cmd.opcode == ldpw_pkg::OP_START)
        begin
            busy_next = 1'b0;
            res.kind  = ldpw_pkg::KIND_REJECT;
            if (!reject)
            begin
                busy_next       = 1'b1;
                res.kind        = ldpw_pkg::KIND_ACCEPT;
                cur_col_next    = cmd.start_x;
                cur_row_next    = cmd.start_y;
                target_col_next = cmd.end_x;
                target_row_next = cmd.end_y;
                col_neg_next    = !(cmd.start_x < cmd.end_x);
                row_neg_next    = !(cmd.start_y < cmd.end_y);
                span_x_next     = {1'b0, dx};
                span_y_neg_next = -$signed({1'b0, dy});
                error_next      = ldpw_pkg::ERR_BITS'($signed({1'b0, dx}))
                                  - ldpw_pkg::ERR_BITS'($signed({1'b0, dy}));
                color_next      = cmd.line_color;
                bytes_next      = cmd_bytes;
                shift_next      = cmd_shift;
                row_addr_next   = cmd.base_address + ldpw_pkg::ADDRESS_BITS'(row_off0);
                pitch_next      = cmd.row_pitch;
            end
        end
        else if (busy_reg)
        begin
            res.kind          = ldpw_pkg::KIND_WRITE;
            res.write_address = 32'(pix_addr);
            res.write_bytes   = bytes_reg;
            res.write_data    = ldpw_pkg::mask_color(color_reg, bytes_reg);
            res.last_pixel    = at_end;
            if (at_end)
            begin
                busy_next = 1'b0;
            end
            else
            begin
                error_next = ldpw_pkg::ERR_BITS'(err_sum);
                if (step_col)
                begin
                    cur_col_next = col_neg_reg ? cur_col_reg - 1'b1 : cur_col_reg + 1'b1;
                end
                if (step_row)
                begin
                    cur_row_next  = row_neg_reg ? cur_row_reg - 1'b1 : cur_row_reg + 1'b1;
                    row_addr_next = row_neg_reg
                                    ? row_addr_reg - ldpw_pkg::ADDRESS_BITS'(pitch_reg)
                                    : row_addr_reg + ldpw_pkg::ADDRESS_BITS'(pitch_reg);
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg       <= 1'b0;
            cur_col_reg    <= '0;
            cur_row_reg    <= '0;
            target_col_reg <= '0;
            target_row_reg <= '0;
            col_neg_reg    <= 1'b0;
            row_neg_reg    <= 1'b0;
            error_reg      <= '0;
            span_x_reg     <= '0;
            span_y_neg_reg <= '0;
            color_reg      <= '0;
            bytes_reg      <= '0;
            shift_reg      <= '0;
            row_addr_reg   <= '0;
            pitch_reg      <= '0;
        end
        else if (advance)
        begin
            busy_reg       <= busy_next;
            cur_col_reg    <= cur_col_next;
            cur_row_reg    <= cur_row_next;
            target_col_reg <= target_col_next;
            target_row_reg <= target_row_next;
            col_neg_reg    <= col_neg_next;
            row_neg_reg    <= row_neg_next;
            error_reg      <= error_next;
            span_x_reg     <= span_x_next;
            span_y_neg_reg <= span_y_neg_next;
            color_reg      <= color_next;
            bytes_reg      <= bytes_next;
            shift_reg      <= shift_next;
            row_addr_reg   <= row_addr_next;
            pitch_reg      <= pitch_next;
        end
    end

    // an active line always has a valid pixel size and pitch
    assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg |-> ((bytes_reg == 3'd1) || (bytes_reg == 3'd2) || (bytes_reg == 3'd4))
                     && (pitch_reg != 16'd0))
        else $error("active line with bad pixel size or pitch");

    assert property (@(posedge clk) disable iff (!rst_n)
        advance && busy_reg && (cmd.opcode == ldpw_pkg::OP_STEP) && at_end |=> !busy_reg)
        else $error("line still active after last pixel");

    assert property (@(posedge clk) disable iff (!rst_n)
        advance && busy_reg && (cmd.opcode == ldpw_pkg::OP_STEP) && !at_end
        |-> (step_col || step_row))
        else $error("step moved neither axis");

endmodule
